@@ rtl/gwas_pkg.sv @@
// Package for the gated window average settle detector.
// Holds the window size, derived widths, status codes and the sequencer states.
// No dependencies.
package gwas_pkg;

  // Window length and derived widths
  localparam int unsigned WINDOW = 8;
  localparam int unsigned CODE_W = 12;
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = CODE_W + SLOT_W;
  localparam int unsigned FRAC_W = 4;
  localparam int unsigned DIV_W  = SUM_W + FRAC_W;
  localparam int unsigned AVG_W  = 16;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned RUN_W  = 4;
  localparam int unsigned DELTA_W = 16;

  // The divider retires two quotient bits per cycle
  localparam int unsigned DIV_STEPS = AVG_W / 2;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_DELTA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUNS_NEEDED  = 1'b1;
  localparam logic [DELTA_W-1:0] DELTA_RESET = 16'd418;
  localparam logic [RUN_W-1:0]   RUNS_RESET  = 4'd3;

  typedef enum logic [1:0] {
    STATUS_IDLE  = 2'd0,
    STATUS_MEAS  = 2'd1,
    STATUS_READY = 2'd2
  } gwas_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DIV,
    S_FIN,
    S_OUT
  } gwas_state_e;

  // The reported fill count is the fill level masked to four bits.
  function automatic logic [CNT_W-1:0] fill_to_count(input logic [FILL_W-1:0] fill);
    logic [FILL_W+CNT_W-1:0] wide;
    wide = {{CNT_W{1'b0}}, fill};
    return wide[CNT_W-1:0];
  endfunction

endpackage

@@ rtl/gwas_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module gwas_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gated_window_average_stability.sv @@
// Gated window average settle detector: one result word for every input word.
// Sequence: an idle (switch released) word goes straight to the output state; a
// measuring word takes one ring read per filled entry (1 to WINDOW), a drain state,
// the divider retiring two quotient bits a cycle, a finish state and the output state.
// No new word is taken until the result enters the output register, so a waiting result
// blocks acceptance. Reset clears the sequencer, run state and registers to defaults.
module gated_window_average_stability (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           switch_active_i,
  input  logic [gwas_pkg::CODE_W-1:0]    adc_code_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_code_o,
  output logic [gwas_pkg::AVG_W-1:0]     average_q4_o,
  output logic [gwas_pkg::CNT_W-1:0]     filled_count_o,
  input  logic                           cfg_we_i,
  input  logic [gwas_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gwas_pkg::DELTA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned FILL_W = gwas_pkg::FILL_W;
  localparam int unsigned SLOT_W = gwas_pkg::SLOT_W;
  localparam int unsigned SUM_W  = gwas_pkg::SUM_W;
  localparam int unsigned DIV_W  = gwas_pkg::DIV_W;
  localparam int unsigned AVG_W  = gwas_pkg::AVG_W;
  localparam int unsigned RUN_W  = gwas_pkg::RUN_W;
  localparam int unsigned CNT_W  = gwas_pkg::CNT_W;
  localparam int unsigned STEP_W = gwas_pkg::STEP_W;

  gwas_pkg::gwas_state_e state_q, state_d;

  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [AVG_W-1:0]   prev_q, prev_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [gwas_pkg::DELTA_W-1:0] delta_q, delta_d;
  logic [RUN_W-1:0]   needed_q, needed_d;

  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic               rd_pend_q, rd_pend_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [FILL_W-1:0]  rem_q, rem_d;
  logic [AVG_W-1:0]   dlo_q, dlo_d;
  logic [AVG_W-1:0]   quo_q, quo_d;
  logic [STEP_W-1:0]  step_q, step_d;

  gwas_pkg::gwas_status_e res_status_q, res_status_d;
  logic [AVG_W-1:0]   res_avg_q, res_avg_d;
  logic [CNT_W-1:0]   res_cnt_q, res_cnt_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q, out_status_d;
  logic [AVG_W-1:0]   out_avg_q, out_avg_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;

  logic                      accept;
  logic                      ram_we;
  logic                      ram_re;
  logic [gwas_pkg::CODE_W-1:0] ram_rdata;

  logic [SUM_W-1:0]   sum_next;
  logic [DIV_W-1:0]   dividend;
  logic [FILL_W:0]    div_t1, div_t2, div_den;
  logic               div_ge1, div_ge2;
  logic [FILL_W:0]    div_r1, div_r2;
  logic [AVG_W-1:0]   avg_diff;
  logic               steady;
  logic [RUN_W-1:0]   run_new;
  logic               ready;

  assign in_stall_o = (state_q != gwas_pkg::S_IDLE);
  assign accept     = in_valid_i && (state_q == gwas_pkg::S_IDLE);

  // Sample ring: written when a measuring word is taken, read one entry a cycle for the sum
  assign ram_we = accept && switch_active_i;
  assign ram_re = (state_q == gwas_pkg::S_READ);

  gwas_ram #(
    .WIDTH (gwas_pkg::CODE_W),
    .DEPTH (gwas_pkg::WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (adc_code_i),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Running sum and the dividend formed from the final sum
  assign sum_next = sum_q + SUM_W'(ram_rdata);
  assign dividend = {sum_next, {gwas_pkg::FRAC_W{1'b0}}};

  // Two restoring division steps per cycle; the partial remainder stays below the fill level
  assign div_den = {1'b0, fill_q};
  assign div_t1  = {rem_q, dlo_q[AVG_W-1]};
  assign div_ge1 = (div_t1 >= div_den);
  assign div_r1  = div_ge1 ? (div_t1 - div_den) : div_t1;
  assign div_t2  = {div_r1[FILL_W-1:0], dlo_q[AVG_W-2]};
  assign div_ge2 = (div_t2 >= div_den);
  assign div_r2  = div_ge2 ? (div_t2 - div_den) : div_t2;

  // Settle tracking on the finished average
  assign avg_diff = (quo_q >= prev_q) ? (quo_q - prev_q) : (prev_q - quo_q);
  assign steady   = (fill_q >= FILL_W'(2)) && (avg_diff <= delta_q);
  assign run_new  = steady ? ((run_q != gwas_pkg::RUN_MAX) ? run_q + RUN_W'(1) : run_q)
                           : RUN_W'(1);
  assign ready    = (fill_q == FILL_W'(gwas_pkg::WINDOW)) && (run_new >= needed_q);

  // Sequencer: next state, datapath updates and the output register
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    fill_d       = fill_q;
    prev_d       = prev_q;
    run_d        = run_q;
    delta_d      = delta_q;
    needed_d     = needed_q;
    idx_d        = idx_q;
    rd_pend_d    = 1'b0;
    sum_d        = sum_q;
    rem_d        = rem_q;
    dlo_d        = dlo_q;
    quo_d        = quo_q;
    step_d       = step_q;
    res_status_d = res_status_q;
    res_avg_d    = res_avg_q;
    res_cnt_d    = res_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_avg_d    = out_avg_q;
    out_cnt_d    = out_cnt_q;

    // Configuration writes must arrive only while the block is idle; nothing here enforces it
    if (cfg_we_i) begin
      case (cfg_index_i)
        gwas_pkg::CFG_SETTLE_DELTA: delta_d  = cfg_wdata_i;
        gwas_pkg::CFG_RUNS_NEEDED:  needed_d = cfg_wdata_i[RUN_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      gwas_pkg::S_IDLE: begin
        if (accept) begin
          if (switch_active_i) begin
            slot_d = (slot_q == SLOT_W'(gwas_pkg::WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
            if (fill_q != FILL_W'(gwas_pkg::WINDOW)) begin
              fill_d = fill_q + FILL_W'(1);
            end
            idx_d   = '0;
            sum_d   = '0;
            state_d = gwas_pkg::S_READ;
          end else begin
            // Switch released: drop the measurement and report idle
            slot_d       = '0;
            fill_d       = '0;
            prev_d       = '0;
            run_d        = '0;
            res_status_d = gwas_pkg::STATUS_IDLE;
            res_avg_d    = '0;
            res_cnt_d    = '0;
            state_d      = gwas_pkg::S_OUT;
          end
        end
      end
      gwas_pkg::S_READ: begin
        if (rd_pend_q) begin
          sum_d = sum_next;
        end
        rd_pend_d = 1'b1;
        idx_d     = idx_q + SLOT_W'(1);
        if (FILL_W'(idx_q) + FILL_W'(1) == fill_q) begin
          state_d = gwas_pkg::S_DRAIN;
        end
      end
      gwas_pkg::S_DRAIN: begin
        // Last entry arrives; load the divider with the sum times sixteen
        rem_d   = FILL_W'(dividend[DIV_W-1:AVG_W]);
        dlo_d   = dividend[AVG_W-1:0];
        quo_d   = '0;
        step_d  = '0;
        state_d = gwas_pkg::S_DIV;
      end
      gwas_pkg::S_DIV: begin
        rem_d  = div_r2[FILL_W-1:0];
        dlo_d  = {dlo_q[AVG_W-3:0], 2'b00};
        quo_d  = {quo_q[AVG_W-3:0], div_ge1, div_ge2};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(gwas_pkg::DIV_STEPS - 1)) begin
          state_d = gwas_pkg::S_FIN;
        end
      end
      gwas_pkg::S_FIN: begin
        prev_d       = quo_q;
        run_d        = run_new;
        res_status_d = ready ? gwas_pkg::STATUS_READY : gwas_pkg::STATUS_MEAS;
        res_avg_d    = quo_q;
        res_cnt_d    = gwas_pkg::fill_to_count(fill_q);
        state_d      = gwas_pkg::S_OUT;
      end
      gwas_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_avg_d    = res_avg_q;
          out_cnt_d    = res_cnt_q;
          state_d      = gwas_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gwas_pkg::S_IDLE;
      end
    endcase
  end

  // Control and measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gwas_pkg::S_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      prev_q      <= '0;
      run_q       <= '0;
      delta_q     <= gwas_pkg::DELTA_RESET;
      needed_q    <= gwas_pkg::RUNS_RESET;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      prev_q      <= prev_d;
      run_q       <= run_d;
      delta_q     <= delta_d;
      needed_q    <= needed_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    sum_q        <= sum_d;
    rem_q        <= rem_d;
    dlo_q        <= dlo_d;
    quo_q        <= quo_d;
    step_q       <= step_d;
    res_status_q <= res_status_d;
    res_avg_q    <= res_avg_d;
    res_cnt_q    <= res_cnt_d;
    out_status_q <= out_status_d;
    out_avg_q    <= out_avg_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_code_o  = out_status_q;
  assign average_q4_o   = out_avg_q;
  assign filled_count_o = out_cnt_q;

endmodule

@@ sim/gwas_settle_checker.sv @@
// Checker for the gated window average settle detector.
// Watches the input, output and register ports, predicts each result word and compares it.
// Depends on gwas_pkg for widths, status codes and register indexes.
module gwas_settle_checker
  import gwas_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 switch_active_i,
  input  logic [CODE_W-1:0]    adc_code_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [1:0]           status_code_i,
  input  logic [AVG_W-1:0]     average_q4_i,
  input  logic [CNT_W-1:0]     filled_count_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DELTA_W-1:0]   cfg_wdata_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    gwas_status_e      status;
    logic [AVG_W-1:0]  average;
    logic [CNT_W-1:0]  count;
  } reading_t;

  // Own copy of the measurement state and the two registers.
  logic [CODE_W-1:0]  ring [WINDOW];
  logic [SLOT_W-1:0]  slot;
  logic [FILL_W-1:0]  fill;
  logic [AVG_W-1:0]   last_mean;
  logic [RUN_W-1:0]   run_len;
  logic [DELTA_W-1:0] settle_delta;
  logic [RUN_W-1:0]   runs_needed;

  reading_t    expected_readings [$];
  int unsigned mismatches;

  // The reported count is the fill level cut to the output width.
  function automatic logic [CNT_W-1:0] fill_count(input logic [FILL_W-1:0] level);
    int unsigned wide;
    wide = level;
    return CNT_W'(wide);
  endfunction

  // Works out the reading that one sample tick gives, and advances the state.
  task automatic predict_reading(input logic active, input logic [CODE_W-1:0] code,
                                 output reading_t res);
    int unsigned total;
    int unsigned mean;
    int unsigned change;
    int unsigned k;
    total = 0;
    if (!active) begin
      // A released switch clears the measurement state but not the ring or the two registers.
      slot = '0;
      fill = '0;
      last_mean = '0;
      run_len = '0;
      res.status = STATUS_IDLE;
      res.average = '0;
      res.count = '0;
    end else begin
      ring[slot] = code;
      slot = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      if (fill < FILL_W'(WINDOW)) fill = fill + 1'b1;
      // Only entries written since the last clear are summed.
      for (k = 0; k < fill; k++) total += ring[k];
      mean = ((total * 16) / fill) & 32'hFFFF;
      change = (mean >= last_mean) ? mean - last_mean : last_mean - mean;
      // The first sample after a clear always starts a fresh run.
      if (fill >= 2 && change <= settle_delta) begin
        if (run_len < RUN_MAX) run_len = run_len + 1'b1;
      end else begin
        run_len = RUN_W'(1);
      end
      last_mean = AVG_W'(mean);
      res.status = (fill >= FILL_W'(WINDOW) && run_len >= runs_needed) ? STATUS_READY
                                                                          : STATUS_MEAS;
      res.average = AVG_W'(mean);
      res.count = fill_count(fill);
    end
  endtask

  // Register writes, accepted input words and accepted result words, in that order.
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      slot = '0;
      fill = '0;
      last_mean = '0;
      run_len = '0;
      settle_delta = DELTA_RESET;
      runs_needed = RUNS_RESET;
      expected_readings.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      words_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SETTLE_DELTA: settle_delta = cfg_wdata_i;
          CFG_RUNS_NEEDED:  runs_needed = cfg_wdata_i[RUN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_reading(switch_active_i, adc_code_i, want);
        expected_readings.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result word: status %0d average %0d count %0d",
                   $time, status_code_i, average_q4_i, filled_count_i);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (status_code_i !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_code_i);
            mismatches++;
          end
          if (average_q4_i !== want.average) begin
            $display("%0t: average expected %0d, got %0d", $time, want.average, average_q4_i);
            mismatches++;
          end
          if (filled_count_i !== want.count) begin
            $display("%0t: filled count expected %0d, got %0d", $time, want.count,
                     filled_count_i);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      words_pending_o <= expected_readings.size();
    end
  end

endmodule

@@ sim/gated_window_average_stability_tb.sv @@
// Testbench top for the gated window average settle detector.
// Drives sample words, register writes and output stalls; depends on gwas_pkg,
// the block itself and gwas_settle_checker, which does all the checking.
module gated_window_average_stability_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gwas_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned DRAIN_GUARD  = 4000;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_WORDS  = 52;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 switch_active;
  logic [CODE_W-1:0]    adc_code;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           status_code;
  logic [AVG_W-1:0]     average_q4;
  logic [CNT_W-1:0]     filled_count;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELTA_W-1:0]   cfg_wdata;
  int unsigned          mismatch_count;
  int unsigned          words_pending;
  logic                 no_gaps;

  gated_window_average_stability dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .switch_active_i (switch_active),
    .adc_code_i      (adc_code),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_code_o   (status_code),
    .average_q4_o    (average_q4),
    .filled_count_o  (filled_count),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  gwas_settle_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .switch_active_i  (switch_active),
    .adc_code_i       (adc_code),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_code_i    (status_code),
    .average_q4_i     (average_q4),
    .filled_count_i   (filled_count),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap lengths for both sides: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one sample word, holds it until accepted, then maybe idles.
  task automatic send_word(input logic active, input logic [CODE_W-1:0] code);
    int unsigned gap;
    in_valid <= 1'b1;
    switch_active <= active;
    adc_code <= code;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap != 0) begin
      // Junk on the payload while nothing is offered.
      in_valid <= 1'b0;
      switch_active <= 1'($urandom);
      adc_code <= CODE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every expected result word has arrived or the guard runs out.
  task automatic wait_drain();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DELTA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Switch presses of random length around a random level, each followed by a release.
  task automatic run_presses(input int unsigned words);
    int unsigned sent;
    int unsigned press_len;
    int unsigned spread;
    int unsigned roll;
    int unsigned k;
    int          base;
    int          code;
    sent = 0;
    while (sent < words) begin
      press_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 30);
      base = $urandom_range(0, 4095);
      roll = $urandom_range(0, 99);
      if (roll < 40) spread = $urandom_range(0, 3);
      else if (roll < 70) spread = $urandom_range(4, 40);
      else if (roll < 90) spread = $urandom_range(41, 400);
      else spread = 4095;
      for (k = 0; k < press_len; k++) begin
        code = base + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (code < 0) code = 0;
        else if (code > 4095) code = 4095;
        send_word(1'b1, CODE_W'(code));
      end
      sent += press_len;
      k = $urandom_range(1, 2);
      repeat (k) send_word(1'b0, CODE_W'($urandom));
      sent += k;
    end
  endtask

  // Receiver: stretches of stall between stretches of free flow.
  initial begin
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Main stimulus and verdict.
  initial begin
    logic [DELTA_W-1:0] delta;
    logic [RUN_W-1:0]   runs;
    int unsigned        p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    switch_active = 1'b0;
    adc_code = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SETTLE_DELTA;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset register values: idle with a live code, the first
    // sample after a clear, a full window going steady, a jump at full window, a release.
    send_word(1'b0, 12'hFFF);
    send_word(1'b1, 12'h000);
    repeat (12) send_word(1'b1, 12'hFFF);
    send_word(1'b1, 12'h000);
    send_word(1'b1, 12'hFFF);
    send_word(1'b0, 12'hFFF);
    repeat (3) send_word(1'b1, 12'h800);
    send_word(1'b0, 12'h000);

    // Register settings, extremes first, then random ones.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin delta = 16'd0;    runs = 4'd1;  end
        1: begin delta = 16'hFFFF; runs = 4'd15; end
        2: begin delta = 16'd418;  runs = 4'd0;  end
        3: begin delta = 16'hFFFF; runs = 4'd0;  end
        4: begin delta = 16'd0;    runs = 4'd15; end
        default: begin
          delta = 16'($urandom_range(0, 2000));
          runs = 4'($urandom);
        end
      endcase
      wait_drain();
      write_reg(CFG_SETTLE_DELTA, delta);
      write_reg(CFG_RUNS_NEEDED, {12'($urandom), runs});
      // One setting runs with no idling on either side.
      no_gaps = (p == 1);
      run_presses(PHASE_WORDS);
    end
    no_gaps = 1'b0;

    wait_drain();
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
